// ----- src/amaxpq_pkg.sv -----
package amaxpq_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 16;
    localparam int OUT_CNT_W = 5;

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef enum logic {
        OP_INSERT,
        OP_DELETE
    } t_op_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_POST
    } t_back_state;

    typedef struct packed {
        t_op_kind         kind;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_push;

    typedef struct packed {
        t_status              status;
        logic [OUT_CNT_W-1:0] count;
        logic [KEY_W-1:0]     max_key;
        logic                 max_valid;
        logic [OUT_CNT_W-1:0] removed;
    } t_result;

endpackage

// ----- src/amaxpq_front.sv -----
module amaxpq_front
    import amaxpq_pkg::*;
(
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_cmd,
    input  logic [KEY_W-1:0] i_key,
    input  logic [TAG_W-1:0] i_tag,
    input  logic             i_full,
    output t_push            o_push
);

    // decode the command; key and tag carry no meaning on a delete
    assign o_in_stall      = i_full;
    assign o_push.valid    = i_in_valid && !i_full;
    assign o_push.req.kind = i_cmd ? OP_DELETE : OP_INSERT;
    assign o_push.req.key  = i_cmd ? '0 : i_key;
    assign o_push.req.tag  = i_cmd ? '0 : i_tag;

endmodule

// ----- src/amaxpq_fifo.sv -----
module amaxpq_fifo
    import amaxpq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output logic  o_valid,
    output t_req  o_req,
    input  logic  i_pop
);

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              push;
    logic              pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rp];
    assign push    = i_push.valid && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

// ----- src/amaxpq_back.sv -----
module amaxpq_back
    import amaxpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_req    i_req,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [TAG_W-1:0] tag_mem [CAPACITY];

    t_back_state      r_state;
    t_back_state      n_state;
    logic [CW-1:0]    r_cnt;
    logic [KEY_W-1:0] r_max;
    logic [CW-1:0]    r_rd;
    logic [CW-1:0]    r_wr;
    logic [CW-1:0]    r_rm;
    logic [KEY_W-1:0] r_nmax;
    logic             r_pend;
    logic [KEY_W-1:0] r_kq;
    logic [TAG_W-1:0] r_tq;
    logic             r_out_valid;
    t_result          r_result;

    logic             out_free;
    logic             full;
    logic             we;
    logic [IW-1:0]    waddr;
    logic [KEY_W-1:0] wkey;
    logic [TAG_W-1:0] wtag;
    logic             re;
    logic             load;
    logic             start_scan;
    logic             ins_ok;
    logic [KEY_W-1:0] ins_max;
    t_result          res;

    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = (r_cnt == CW'(CAPACITY));
    assign ins_max  = ((r_cnt == '0) || (i_req.key > r_max)) ? i_req.key : r_max;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_req_valid && out_free && i_req.kind == OP_DELETE && r_cnt != '0) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (r_rd == r_cnt && !r_pend) begin
                    n_state = BK_POST;
                end
            end
            BK_POST: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        we         = 1'b0;
        waddr      = r_cnt[IW-1:0];
        wkey       = i_req.key;
        wtag       = i_req.tag;
        re         = 1'b0;
        load       = 1'b0;
        start_scan = 1'b0;
        ins_ok     = 1'b0;
        res        = '{status: ST_OK, count: OUT_CNT_W'(r_cnt), max_key: r_max,
                       max_valid: (r_cnt != '0), removed: '0};
        unique case (r_state)
            BK_IDLE: begin
                if (i_req_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_req.kind == OP_INSERT) begin
                        load = 1'b1;
                        if (full) begin
                            res.status = ST_FULL;
                        end else begin
                            we            = 1'b1;
                            ins_ok        = 1'b1;
                            res.count     = OUT_CNT_W'(CW'(r_cnt + 1'b1));
                            res.max_key   = ins_max;
                            res.max_valid = 1'b1;
                        end
                    end else if (r_cnt == '0) begin
                        load       = 1'b1;
                        res.status = ST_EMPTY;
                    end else begin
                        start_scan = 1'b1;
                    end
                end
            end
            BK_SCAN: begin
                re = (r_rd != r_cnt);
                if (r_pend && r_kq != r_max) begin
                    we    = 1'b1;
                    waddr = r_wr[IW-1:0];
                    wkey  = r_kq;
                    wtag  = r_tq;
                end
            end
            BK_POST: begin
                load          = out_free;
                res.count     = OUT_CNT_W'(r_wr);
                res.max_key   = r_nmax;
                res.max_valid = (r_wr != '0);
                res.removed   = OUT_CNT_W'(r_rm);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            key_mem[waddr] <= wkey;
            tag_mem[waddr] <= wtag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_kq <= key_mem[r_rd[IW-1:0]];
            r_tq <= tag_mem[r_rd[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
            r_max   <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_rm    <= '0;
            r_nmax  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ins_ok) begin
                r_cnt <= CW'(r_cnt + 1'b1);
                r_max <= ins_max;
            end
            if (start_scan) begin
                r_rd   <= '0;
                r_wr   <= '0;
                r_rm   <= '0;
                r_nmax <= '0;
                r_pend <= 1'b0;
            end
            if (r_state == BK_SCAN) begin
                r_pend <= re;
                if (re) begin
                    r_rd <= CW'(r_rd + 1'b1);
                end
                if (r_pend) begin
                    if (r_kq == r_max) begin
                        r_rm <= CW'(r_rm + 1'b1);
                    end else begin
                        r_wr <= CW'(r_wr + 1'b1);
                        if (r_kq > r_nmax) begin
                            r_nmax <= r_kq;
                        end
                    end
                end
            end
            if (r_state == BK_POST && out_free) begin
                r_cnt <= r_wr;
                r_max <= r_nmax;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// ----- src/array_max_priority_queue_unit.sv -----
// Bounded max-priority queue of (key, tag) entries with a running maximum.
// Request channel: i_in_valid / o_in_stall with i_cmd, i_key, i_tag. A request
// is taken at a clock edge where i_in_valid is high and o_in_stall is low.
// i_cmd 0 inserts (key, tag); i_cmd 1 deletes every entry holding the maximum.
// Result channel: o_out_valid / i_out_stall with o_status, o_count, o_max_key,
// o_max_valid, o_removed; exactly one result per request, in request order.
// A front decoder pushes requests into a two-entry queue; the back executes.
// Insert and delete-on-empty results: the request is written into the queue, then
// loads the output register once the back is idle and the output is free.
// A delete on N stored entries walks the key memory one entry a cycle through its
// registered read port before loading its result; the back takes no new request
// until that walk and its result are done, so the walk limits delete throughput.
// Inserts sustain one per cycle while the result side keeps up.
// Reset (synchronous, active low) empties the queue, clears count and maximum
// and drops any pending request or result. The key/tag memories are not cleared.
// When the receiver stalls, the result register holds; the back then stops
// pulling requests and the queue fills until o_in_stall rises.
module array_max_priority_queue_unit
    import amaxpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [OUT_CNT_W-1:0] o_count,
    output logic [KEY_W-1:0]     o_max_key,
    output logic                 o_max_valid,
    output logic [OUT_CNT_W-1:0] o_removed
);

    t_push   push;
    logic    q_full;
    logic    q_valid;
    t_req    q_req;
    logic    q_pop;
    t_result result;

    // decode requests and stall on a full queue
    amaxpq_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .i_tag      (i_tag),
        .i_full     (q_full),
        .o_push     (push)
    );

    // hold decoded requests while the back is busy with a delete walk
    amaxpq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (q_pop)
    );

    // execute: store, compact, track the maximum, register the result
    amaxpq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (q_valid),
        .i_req       (q_req),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_status    = result.status;
    assign o_count     = result.count;
    assign o_max_key   = result.max_key;
    assign o_max_valid = result.max_valid;
    assign o_removed   = result.removed;

endmodule

// ----- src/amaxpq_chk.sv -----
module amaxpq_chk
    import amaxpq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 i_cmd,
    input logic [KEY_W-1:0]     i_key,
    input logic [TAG_W-1:0]     i_tag,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_status,
    input logic [OUT_CNT_W-1:0] o_count,
    input logic [KEY_W-1:0]     o_max_key,
    input logic                 o_max_valid,
    input logic [OUT_CNT_W-1:0] o_removed
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_count) && $stable(o_max_key) && $stable(o_removed))
        else $error("stalled result changed");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // an empty queue reports no maximum
    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_max_valid |-> o_count == '0 && o_max_key == '0)
        else $error("empty queue reports a maximum");

    // refused requests remove nothing; delete on empty leaves it empty
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_EMPTY)
            |-> o_removed == '0 && (o_status == ST_FULL || !o_max_valid))
        else $error("error result inconsistent");

endmodule

bind array_max_priority_queue_unit amaxpq_chk u_chk (.*);

// ----- verif/tb_top.sv -----
module tb_top;
    import amaxpq_pkg::*;

    localparam int SLOTS        = 16;
    localparam int FIRST_SPAN   = 800;    // random requests before the pressure section
    localparam int SECOND_SPAN  = 811;    // random requests after it
    localparam int SQUEEZE      = 14;     // requests offered while results are held off
    localparam int HOLD_CYCLES  = 90;     // length of the long result hold
    localparam int DRAIN_LIMIT  = 5000;   // cycles to wait for outstanding results
    localparam int SETTLE       = 40;     // quiet cycles at the end, above a full delete walk

    // Shadow copy of the queue: predicts each result and keeps the
    // predictions in order until the block delivers them.
    class max_queue_tracker;
        logic [KEY_W-1:0] keys [SLOTS];
        logic [TAG_W-1:0] tags [SLOTS];
        int               stored;
        logic [KEY_W-1:0] top_key;
        t_result          pending_outcomes [$];
        int               errors;
        int               inserts;
        int               refused;
        int               deletes;
        int               empty_deletes;
        int               multi_removals;

        function new();
            stored         = 0;
            top_key        = '0;
            errors         = 0;
            inserts        = 0;
            refused        = 0;
            deletes        = 0;
            empty_deletes  = 0;
            multi_removals = 0;
        endfunction

        function void note_request(t_op_kind kind, logic [KEY_W-1:0] key,
                                   logic [TAG_W-1:0] tag);
            t_result outcome;
            int      kept;
            int      dropped;
            outcome        = '0;
            outcome.status = ST_OK;
            dropped        = 0;
            if (kind == OP_INSERT) begin
                inserts++;
                if (stored >= SLOTS) begin
                    outcome.status = ST_FULL;
                    refused++;
                end else begin
                    keys[stored] = key;
                    tags[stored] = tag;
                    if (stored == 0 || key > top_key)
                        top_key = key;
                    stored++;
                end
            end else begin
                deletes++;
                if (stored == 0) begin
                    outcome.status = ST_EMPTY;
                    empty_deletes++;
                end else begin
                    // drop every copy of the maximum, keep survivors in order
                    kept = 0;
                    for (int rd = 0; rd < stored; rd++) begin
                        if (keys[rd] == top_key) begin
                            dropped++;
                        end else begin
                            keys[kept] = keys[rd];
                            tags[kept] = tags[rd];
                            kept++;
                        end
                    end
                    stored  = kept;
                    top_key = '0;
                    for (int i = 0; i < stored; i++)
                        if (keys[i] > top_key)
                            top_key = keys[i];
                    if (dropped > 1)
                        multi_removals++;
                end
            end
            outcome.count     = OUT_CNT_W'(stored);
            outcome.max_key   = top_key;
            outcome.max_valid = (stored != 0);
            outcome.removed   = OUT_CNT_W'(dropped);
            pending_outcomes.push_back(outcome);
        endfunction

        function void compare_field(string field, logic [KEY_W-1:0] want,
                                    logic [KEY_W-1:0] seen);
            if (seen !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
                errors++;
            end
        endfunction

        function void check_outcome(t_result seen);
            t_result want;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with no request outstanding, status %0h count %0h",
                         $time, seen.status, seen.count);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("status", want.status, seen.status);
            compare_field("count", want.count, seen.count);
            compare_field("max_key", want.max_key, seen.max_key);
            compare_field("max_valid", want.max_valid, seen.max_valid);
            compare_field("removed", want.removed, seen.removed);
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_cmd       = 1'b0;
    logic [KEY_W-1:0]     i_key       = '0;
    logic [TAG_W-1:0]     i_tag       = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic [OUT_CNT_W-1:0] o_count;
    logic [KEY_W-1:0]     o_max_key;
    logic                 o_max_valid;
    logic [OUT_CNT_W-1:0] o_removed;

    max_queue_tracker tracker;
    bit               long_hold_pending = 1'b0;
    int               long_holds        = 0;

    array_max_priority_queue_unit #(
        .CAPACITY (SLOTS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .i_tag       (i_tag),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_max_key   (o_max_key),
        .o_max_valid (o_max_valid),
        .o_removed   (o_removed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watch both handshakes at the clock edge: predict on every accepted
    // request, check on every accepted result.
    always @(posedge i_clk) begin : watch_ports
        t_result seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                tracker.note_request(t_op_kind'(i_cmd), i_key, i_tag);
            if (o_out_valid && !i_out_stall) begin
                seen.status    = t_status'(o_status);
                seen.count     = o_count;
                seen.max_key   = o_max_key;
                seen.max_valid = o_max_valid;
                seen.removed   = o_removed;
                tracker.check_outcome(seen);
            end
        end
    end

    // Result side: stall in stretches of varying character. A long hold,
    // when requested, takes priority and is counted here cycle by cycle.
    initial begin : receiver
        int mode;
        int span;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold_pending) begin
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
                long_hold_pending = 1'b0;
                long_holds++;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 120);
                for (int c = 0; c < span && !long_hold_pending; c++) begin
                    case (mode)
                        0: begin
                            i_out_stall <= 1'b0;
                        end
                        1: begin
                            i_out_stall <= ($urandom_range(0, 99) < 30);
                        end
                        2: begin
                            i_out_stall <= ($urandom_range(0, 99) < 80);
                        end
                        default: begin
                            i_out_stall <= c[0];
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Present one request and hold it until it is taken.
    task automatic offer(t_op_kind kind, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
        i_in_valid <= 1'b1;
        i_cmd      <= kind;
        i_key      <= key;
        i_tag      <= tag;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid for a number of cycles; callers never pass zero.
    task automatic idle_for(int cycles);
        i_in_valid <= 1'b0;
        i_cmd      <= 1'($urandom);
        i_key      <= KEY_W'($urandom);
        i_tag      <= TAG_W'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending until every predicted result has come back or DRAIN_LIMIT runs out.
    task automatic wait_drained();
        int waited;
        waited     = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (tracker.pending_outcomes.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    // Nearly half from six repeating keys so deletes hit duplicate maxima; some
    // extremes; the rest anywhere in the range.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return KEY_W'($urandom_range(0, 5) * 16'h2493);
        else if (roll < 55)
            return $urandom_range(0, 1) ? '1 : '0;
        else
            return KEY_W'($urandom);
    endfunction

    // Bursts of requests under a slowly changing mix: filling, draining
    // or balanced, so the queue swings between empty and full.
    task automatic random_traffic(int items);
        int sent;
        int regime;
        int burst;
        int roll;
        int delete_pct;
        sent   = 0;
        regime = $urandom_range(0, 2);
        while (sent < items) begin
            if ($urandom_range(0, 5) == 0)
                regime = $urandom_range(0, 2);
            case (regime)
                0:       delete_pct = 15;
                1:       delete_pct = 65;
                default: delete_pct = 40;
            endcase
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < items; b++) begin
                if ($urandom_range(0, 99) < delete_pct)
                    offer(OP_DELETE, KEY_W'($urandom), TAG_W'($urandom));
                else
                    offer(OP_INSERT, pick_key(), TAG_W'($urandom));
                sent++;
            end
            roll = $urandom_range(0, 9);
            if (roll >= 4 && roll <= 7)
                idle_for($urandom_range(1, 4));
            else if (roll == 8)
                idle_for($urandom_range(5, 12));
            else if (roll == 9)
                idle_for($urandom_range(20, 40));
        end
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0] fill_key;
        tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: delete on an empty queue with junk key and tag.
        offer(OP_DELETE, '1, '1);
        // Extremes, a duplicated maximum, then delete down to empty.
        offer(OP_INSERT, '0, '0);
        offer(OP_INSERT, '1, '1);
        offer(OP_INSERT, '1, 16'h0001);
        offer(OP_DELETE, 16'h1234, 16'h5678);
        offer(OP_DELETE, '0, '0);
        // Fill every slot; the maximum appears six times.
        for (int i = 0; i < SLOTS; i++) begin
            fill_key = (i % 3 == 0) ? 16'hAAAA : (16'h5555 ^ KEY_W'(i * 16'h0101));
            offer(OP_INSERT, fill_key, ~fill_key ^ TAG_W'(i));
        end
        // Insert into a full queue, then clear the top two key levels.
        offer(OP_INSERT, 16'hFFFE, 16'hFFFF);
        offer(OP_DELETE, 16'hFFFF, 16'h0000);
        offer(OP_DELETE, 16'h0000, 16'hFFFF);

        random_traffic(FIRST_SPAN);

        // Pressure: pause for a full drain, then keep offering while the
        // result side is held off so the block backs up into its input.
        wait_drained();
        long_hold_pending = 1'b1;
        for (int i = 0; i < SQUEEZE; i++)
            offer(($urandom_range(0, 3) == 0) ? OP_DELETE : OP_INSERT, pick_key(),
                  TAG_W'($urandom));

        random_traffic(SECOND_SPAN);

        // Wind down: collect what is outstanding, then watch for strays.
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.pending_outcomes.size() != 0) begin
            $display("%0t: %0d result(s) never arrived", $time,
                     tracker.pending_outcomes.size());
            tracker.errors++;
        end

        $display("Covered %0d inserts (%0d refused while full) and %0d deletes",
                 tracker.inserts, tracker.refused, tracker.deletes);
        $display("(%0d on an empty queue, %0d removing duplicate maxima), %0d long hold(s).",
                 tracker.empty_deletes, tracker.multi_removals, long_holds);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #8000000;
        $display("%0t: run did not finish in time", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
